// File: rtl/icc_pkg.sv
// Shared types and constants of the identifier case converter.
// No dependencies; used by every module of the block.
package icc_pkg;

   // casing_mode codes
   localparam logic [1:0] MODE_CAMEL  = 2'd0;
   localparam logic [1:0] MODE_PASCAL = 2'd1;
   localparam logic [1:0] MODE_UPPER  = 2'd2;
   localparam logic [1:0] MODE_SNAKE  = 2'd3;

   // item kinds on req_tuser
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // configuration register indexes
   localparam logic REG_CASING  = 1'b0;
   localparam logic REG_BUF_LEN = 1'b1;

   localparam logic [1:0]  RESET_CASING  = MODE_CAMEL;
   localparam logic [15:0] RESET_BUF_LEN = 16'd256;

   localparam logic [7:0] UNDERSCORE = 8'h5F;
   localparam logic [7:0] TERMINATOR = 8'h00;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified item: one or two results to send.
   typedef struct packed {
      logic       two;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       is_end;
      logic       fits;
   } entry_type;

endpackage

// File: rtl/identifier_case_converter_unit.sv
// Identifier case converter: rewrites an identifier, one byte per transfer,
// into camel, pascal, upper or snake casing and closes it with a terminator
// that reports whether the output fit in buf_len. One input transfer is
// accepted per cycle while the queue is not full; a byte that gets an
// inserted underscore yields two results, sent one after the other, and the
// 4-entry queue between the front end and the output register absorbs them.
// An input passes through a queue slot, then the output register. The user
// must write configuration only while the block is idle; it is not enforced.
// Depends on icc_pkg, icc_front, icc_queue and icc_back.
module identifier_case_converter_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // is_end
   output logic        rsp_tuser,   // fits
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic               push, pop, full, empty;
   icc_pkg::entry_type push_entry, head;

   icc_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   icc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   icc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (empty),
      .q_head     (head),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: rtl/icc_front.sv
// Front end: takes input items, keeps the casing state and output count,
// and turns each item into at most one queue entry. Depends on icc_pkg.
module icc_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // in_byte
   input  logic                  req_tuser,   // mode
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  queue_full,
   output logic                  push,
   output icc_pkg::entry_type    push_entry
);

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   logic [1:0]            casing_ff;
   logic [15:0]           buf_len_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  need_cap_ff, need_cap_in;
   logic                  prev_low_ff, prev_low_in;
   logic                  at_start_ff, at_start_in;
   logic                  ovf_ff, ovf_in;

   logic                  accept;
   logic [7:0]            c;
   logic                  want_ins, want_byte, ok_ins, ok_byte;
   logic [7:0]            byte_val;
   logic [COUNT_BITS-1:0] cnt_a;

   function automatic logic is_upper(input logic [7:0] ch);
      return (ch >= 8'h41) && (ch <= 8'h5A);
   endfunction

   function automatic logic is_lower(input logic [7:0] ch);
      return (ch >= 8'h61) && (ch <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= 8'h30) && (ch <= 8'h39);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] ch);
      return is_lower(ch) ? ch - 8'h20 : ch;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] ch);
      return is_upper(ch) ? ch + 8'h20 : ch;
   endfunction

   function automatic logic can_put(input logic [COUNT_BITS-1:0] cnt,
                                    input logic [15:0] cap);
      return (CMP_W'(cnt) < CMP_W'(cap)) && (cnt != CNT_MAX);
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt);
      return (cnt == CNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
   endfunction

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;

   always_comb begin
      count_in    = count_ff;
      need_cap_in = need_cap_ff;
      prev_low_in = prev_low_ff;
      at_start_in = at_start_ff;
      ovf_in      = ovf_ff;
      want_ins    = 1'b0;
      want_byte   = 1'b0;
      byte_val    = c;
      ok_ins      = 1'b0;
      ok_byte     = 1'b0;
      cnt_a       = count_ff;
      push        = 1'b0;
      push_entry  = '0;
      if (accept) begin
         if (req_tuser == icc_pkg::KIND_END) begin
            push                   = 1'b1;
            push_entry.first_byte  = icc_pkg::TERMINATOR;
            push_entry.is_end      = 1'b1;
            push_entry.fits        = !ovf_ff && can_put(count_ff, buf_len_ff);
            count_in               = '0;
            need_cap_in            = (casing_ff == icc_pkg::MODE_PASCAL);
            prev_low_in            = (casing_ff == icc_pkg::MODE_SNAKE);
            at_start_in            = 1'b1;
            ovf_in                 = 1'b0;
         end else begin
            unique case (casing_ff)
               icc_pkg::MODE_CAMEL, icc_pkg::MODE_PASCAL: begin
                  if (casing_ff == icc_pkg::MODE_CAMEL && at_start_ff) begin
                     want_byte = 1'b1;
                     byte_val  = to_lower(c);
                  end else if (c == icc_pkg::UNDERSCORE) begin
                     need_cap_in = 1'b1;
                  end else if (need_cap_ff) begin
                     want_byte   = 1'b1;
                     byte_val    = to_upper(c);
                     need_cap_in = 1'b0;
                  end else begin
                     want_byte = 1'b1;
                  end
               end
               icc_pkg::MODE_UPPER: begin
                  want_byte = 1'b1;
                  if (!is_upper(c) && c != icc_pkg::UNDERSCORE && !is_digit(c)) begin
                     byte_val    = to_upper(c);
                     prev_low_in = 1'b1;
                  end else begin
                     want_ins    = prev_low_ff;
                     prev_low_in = 1'b0;
                  end
               end
               icc_pkg::MODE_SNAKE: begin
                  want_byte = 1'b1;
                  if (is_upper(c)) begin
                     want_ins    = prev_low_ff && (count_ff != '0);
                     prev_low_in = 1'b0;
                     byte_val    = to_lower(c);
                  end else begin
                     prev_low_in = 1'b1;
                  end
               end
               default: ;
            endcase
            // underscore goes first, the byte then counts after it
            ok_ins   = can_put(count_ff, buf_len_ff);
            cnt_a    = want_ins ? sat_inc(count_ff) : count_ff;
            ok_byte  = can_put(cnt_a, buf_len_ff);
            count_in = want_byte ? sat_inc(cnt_a) : cnt_a;
            ovf_in   = ovf_ff || (want_ins && !ok_ins) || (want_byte && !ok_byte);
            at_start_in = 1'b0;
            push = (want_ins && ok_ins) || (want_byte && ok_byte);
            if (want_ins && ok_ins) begin
               push_entry.first_byte  = icc_pkg::UNDERSCORE;
               push_entry.second_byte = byte_val;
               push_entry.two         = want_byte && ok_byte;
            end else begin
               push_entry.first_byte  = byte_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         casing_ff   <= icc_pkg::RESET_CASING;
         buf_len_ff  <= icc_pkg::RESET_BUF_LEN;
         count_ff    <= '0;
         need_cap_ff <= (icc_pkg::RESET_CASING == icc_pkg::MODE_PASCAL);
         prev_low_ff <= (icc_pkg::RESET_CASING == icc_pkg::MODE_SNAKE);
         at_start_ff <= 1'b1;
         ovf_ff      <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == icc_pkg::REG_CASING) begin
            casing_ff   <= csr_wdata[1:0];
            count_ff    <= '0;
            need_cap_ff <= (csr_wdata[1:0] == icc_pkg::MODE_PASCAL);
            prev_low_ff <= (csr_wdata[1:0] == icc_pkg::MODE_SNAKE);
            at_start_ff <= 1'b1;
            ovf_ff      <= 1'b0;
         end else begin
            buf_len_ff <= csr_wdata;
         end
      end else begin
         count_ff    <= count_in;
         need_cap_ff <= need_cap_in;
         prev_low_ff <= prev_low_in;
         at_start_ff <= at_start_in;
         ovf_ff      <= ovf_in;
      end
   end

endmodule

// File: rtl/icc_queue.sv
// Short FIFO of classified entries between front and back end.
// Depends on icc_pkg for the entry type and depth.
module icc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  icc_pkg::entry_type  push_entry,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output icc_pkg::entry_type  head
);

   icc_pkg::entry_type slots_ff [icc_pkg::QUEUE_DEPTH];
   logic [icc_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [icc_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [icc_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == icc_pkg::QUEUE_CNT_W'(icc_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + icc_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + icc_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + icc_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - icc_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= icc_pkg::QUEUE_CNT_W'(icc_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

// File: rtl/icc_back.sv
// Back end: sends each queue entry as one or two results through the
// output register. Depends on icc_pkg.
module icc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  icc_pkg::entry_type  q_head,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // out_byte
   output logic                rsp_tlast,   // is_end
   output logic                rsp_tuser    // fits
);

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       fits_ff, fits_in;
   logic       load;

   // second_ff: the head entry's first result has already gone out
   assign load  = (!valid_ff || rsp_tready) && !q_empty;
   assign q_pop = load && (!q_head.two || second_ff);

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      second_in = second_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      fits_in   = fits_ff;
      if (load) begin
         valid_in  = 1'b1;
         second_in = q_head.two && !second_ff;
         data_in   = second_ff ? q_head.second_byte : q_head.first_byte;
         last_in   = q_head.is_end;
         fits_in   = q_head.fits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      fits_ff <= fits_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = fits_ff;

`ifndef ASSERT_OFF
   a_second_has_entry: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !q_empty)
      else $error("second half pending without queue entry");
   a_end_terminator: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (data_ff == icc_pkg::TERMINATOR))
      else $error("end result without terminator");
   a_end_single: assert property (@(posedge clock) disable iff (reset)
      (!q_empty && q_head.is_end) |-> !q_head.two)
      else $error("end entry carries two results");
`endif

endmodule
